// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every check runs on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the block clock, gated by reset.
`define SDAW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Implication form of the check above.
`define SDAW_ASSERT_IMP(lbl, ante, cons, msg) \
    `SDAW_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: hdl/sdaw_pkg.sv
// ----------------------------------------------------------------------------
// sdaw_pkg
// Shared constants and types for the signed decimal ASCII writer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdaw_pkg;

    localparam int VALUE_W  = 32;   // input word width
    localparam int DIGIT_W  = 4;    // one BCD digit
    localparam int DIGITS   = 10;   // enough for 2147483648
    localparam int CHAR_W   = 7;
    localparam int LEFT_W   = $clog2(DIGITS + 1);
    localparam int CNT_W    = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;

    // Control shared by every digit cell in the chain.
    typedef struct packed {
        logic clr;      // load zero
        logic dabble;   // add-3 then shift in one bit from below
        logic shift;    // take the digit of the lower neighbor
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: hdl/sdaw_bcd_cell.sv
// ----------------------------------------------------------------------------
// sdaw_bcd_cell
// One BCD digit of the conversion chain: double-dabble step or digit shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sdaw_bcd_cell
    import sdaw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_cell_ctrl         i_ctrl,
    input  wire logic               i_bit,    // carry from lower cell (or input bit)
    input  wire logic [DIGIT_W-1:0] i_digit,  // digit of lower cell
    output      logic               o_carry,
    output      logic [DIGIT_W-1:0] o_digit
);

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] adj;

    // add 3 when the digit would reach 10 or more after doubling
    assign adj     = (r_digit >= DIGIT_W'(5)) ? r_digit + DIGIT_W'(3) : r_digit;
    assign o_carry = adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clr) begin
            n_digit = '0;
        end else if (i_ctrl.dabble) begin
            n_digit = {adj[DIGIT_W-2:0], i_bit};
        end else if (i_ctrl.shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

`default_nettype wire

// File: hdl/signed_decimal_ascii_writer_unit.sv
// ----------------------------------------------------------------------------
// signed_decimal_ascii_writer_unit
// Prints a signed 32-bit word as decimal ASCII text, one character per strobe.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_value and pulse start while busy is low; the word is
//   taken at that edge and busy rises on the next cycle.
//   Output: each character appears on o_char_code for one cycle with
//   o_strobe high; o_last marks the final character. A negative number
//   leads with '-', zero gives a single '0', no leading zeros.
//   Sequence: bit-serial conversion through a chain of ten BCD digit
//   cells, then the chain is walked out (one step per leading zero
//   skipped, one per digit) plus one step that carries the sign or
//   stays empty. busy stays high for the same span whatever the value,
//   and a new word is taken only while busy is low.
//   busy drops in the cycle that registers the last character, so the next
//   start may coincide with the final strobe.
//   Reset (i_rst_n low, synchronous) returns the block to idle and drops
//   the strobe. The receiver cannot stall; it must take every strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_decimal_ascii_writer_unit
    import sdaw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output      logic               busy,
    input  wire logic [VALUE_W-1:0] i_value,
    output      logic               o_strobe,
    output      logic [CHAR_W-1:0]  o_char_code,
    output      logic               o_last
);

    `include "assert_macros.svh"

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;   // double dabble, one bit per cycle
    localparam logic [1:0] S_SKIP = 2'd2;   // drop leading zeros, emit sign
    localparam logic [1:0] S_EMIT = 2'd3;   // one digit per cycle

    logic [1:0]         r_state, n_state;
    logic [VALUE_W-1:0] r_mag, n_mag;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [LEFT_W-1:0]  r_left, n_left;     // digits still in the chain
    logic               r_neg, n_neg;
    logic               r_sign_done, n_sign_done;
    logic               r_strobe, n_strobe;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;

    t_cell_ctrl         ctrl;
    logic               accept;
    logic [DIGIT_W-1:0] digit [DIGITS];
    logic               carry [DIGITS];
    logic [DIGIT_W-1:0] top_digit;

    assign accept    = start && (r_state == S_IDLE);
    assign busy      = (r_state != S_IDLE);
    assign top_digit = digit[DIGITS-1];

    // ---- digit chain: cell 0 is least significant ----
    for (genvar g = 0; g < DIGITS; g++) begin : g_cell
        logic               bit_in;
        logic [DIGIT_W-1:0] dig_in;
        if (g == 0) begin : g_first
            assign bit_in = r_mag[VALUE_W-1];
            assign dig_in = '0;
        end else begin : g_rest
            assign bit_in = carry[g-1];
            assign dig_in = digit[g-1];
        end
        sdaw_bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_bit   (bit_in),
            .i_digit (dig_in),
            .o_carry (carry[g]),
            .o_digit (digit[g])
        );
    end

    // ---- sequencer ----
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_neg       = r_neg;
        n_sign_done = r_sign_done;
        n_strobe    = 1'b0;
        n_char      = r_char;
        n_last      = r_last;
        ctrl        = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    ctrl.clr    = 1'b1;
                    n_neg       = i_value[VALUE_W-1];
                    // 2's complement negate; the most negative value maps to 2^31
                    n_mag       = i_value[VALUE_W-1] ? (~i_value + VALUE_W'(1)) : i_value;
                    n_cnt       = '0;
                    n_left      = LEFT_W'(DIGITS);
                    n_sign_done = 1'b0;
                    n_state     = S_CONV;
                end
            end
            S_CONV: begin
                ctrl.dabble = 1'b1;
                n_mag       = {r_mag[VALUE_W-2:0], 1'b0};
                n_cnt       = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (top_digit == '0 && r_left > LEFT_W'(1)) begin
                    ctrl.shift = 1'b1;
                    n_left     = r_left - LEFT_W'(1);
                end else if (r_neg && !r_sign_done) begin
                    n_strobe    = 1'b1;
                    n_char      = ASCII_MINUS;
                    n_last      = 1'b0;
                    n_sign_done = 1'b1;
                    n_state     = S_EMIT;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                ctrl.shift = 1'b1;
                n_strobe   = 1'b1;
                n_char     = ASCII_ZERO + CHAR_W'(top_digit);
                n_last     = (r_left == LEFT_W'(1));
                n_left     = r_left - LEFT_W'(1);
                if (r_left == LEFT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_mag       <= n_mag;
        r_cnt       <= n_cnt;
        r_left      <= n_left;
        r_neg       <= n_neg;
        r_sign_done <= n_sign_done;
        r_char      <= n_char;
        r_last      <= n_last;
    end

    assign o_strobe    = r_strobe;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    // ---- checks ----
    `SDAW_ASSERT_IMP(a_busy_after_accept, accept, ##1 busy, "accepted word did not raise busy")
    `SDAW_ASSERT_IMP(a_quiet_after_last, o_strobe && o_last, ##1 !o_strobe,
        "strobe right after last character")
    `SDAW_ASSERT_IMP(a_minus_not_last, o_strobe && o_char_code == ASCII_MINUS, !o_last,
        "minus sign flagged as last")
    `SDAW_ASSERT_IMP(a_no_strobe_in_conv, r_state == S_CONV, !n_strobe,
        "character emitted during conversion")

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the signed decimal ASCII writer character by character.
// Each word sent on start/busy is turned here into its expected decimal text:
// a minus sign for negatives, no leading zeros, and last set on the final
// character. Every strobed character is compared against the oldest pending
// expectation. Phases cover the edge values first, then random words with
// the sender running back to back, idling often, and idling now and then.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import sdaw_pkg::*;

    localparam int          HALF_PERIOD   = 6;      // 12 ns clock
    localparam int          RESET_CYCLES  = 5;
    localparam int unsigned RADIX         = 10;
    localparam int          MAX_DIGITS    = 10;     // 2147483648 has ten digits
    localparam int          SETTLE_CYCLES = 60;     // past the time a word takes
    localparam int          STALL_LIMIT   = 4000;   // cycles with no word moving
    localparam int          REPORT_LIMIT  = 10;

    // One character of expected text.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [VALUE_W-1:0] i_value;
    logic               o_strobe;
    logic [CHAR_W-1:0]  o_char_code;
    logic               o_last;

    t_text_char pending_chars[$];   // expected text, oldest character first
    t_text_char want_char;
    int         mismatch_count = 0;
    int         stall_cycles   = 0;
    int         idle_pct       = 0;  // chance per slot that the sender holds off

    signed_decimal_ascii_writer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Decimal text predictor: minus sign first for negatives, then the digits
    // of the magnitude, most significant first. The magnitude is formed in
    // 32-bit unsigned terms, so -2147483648 gives 2147483648 exactly.
    // ------------------------------------------------------------------------
    task automatic push_decimal_text(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] mag;
        int unsigned        digits[MAX_DIGITS];
        int                 n;
        mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
        n   = 0;
        do begin
            digits[n] = mag % RADIX;
            mag       = mag / RADIX;
            n++;
        end while (mag != 0 && n < MAX_DIGITS);
        if (value[VALUE_W-1]) begin
            pending_chars.push_back('{code: ASCII_MINUS, last: 1'b0});
        end
        for (int i = n - 1; i >= 0; i--) begin
            pending_chars.push_back('{code: ASCII_ZERO + CHAR_W'(digits[i]),
                                      last: (i == 0)});
        end
    endtask

    // ------------------------------------------------------------------------
    // Mismatch log: the first few in full, the rest only counted.
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: raise start with the word at a falling edge and hold it until
    // a rising edge sees busy low. The expected text is queued at that edge.
    // Start stays high into the next word unless the sender decides to idle;
    // each step assigns start at most once.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [VALUE_W-1:0] value);
        int gap;
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        push_decimal_text(value);

        // Short gaps one slot at a time, plus now and then a long one so the
        // next start lands anywhere in the block's conversion and output.
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct && gap < 20) gap++;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 2) begin
            gap += $urandom_range(1, 70);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            start   <= 1'b0;
            i_value <= $urandom;    // junk while idle, must be ignored
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Random word with a random magnitude size, so short and long texts
    // both show up; about half come out negative.
    function automatic logic [VALUE_W-1:0] random_word();
        int                 bits;
        logic [VALUE_W-1:0] w;
        bits = $urandom_range(0, VALUE_W);
        w    = $urandom;
        if (bits < VALUE_W) w &= (32'd1 << bits) - 1;
        if ($urandom_range(0, 1)) w = ~w + 1'b1;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Edge values: zero, single digits, decade boundaries, both extremes.
    task automatic test_edge_values();
        logic [VALUE_W-1:0] words[$];
        idle_pct = 0;
        words = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                  -32'sd9, 32'd999999999, 32'd1000000000, -32'sd1000000000,
                  32'd1234567890, -32'sd1234567890, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1000000007,
                  32'd0, 32'h8000_0000};
        foreach (words[i]) send_word(words[i]);
    endtask

    task automatic test_random_words(input int count, input int idle_chance);
        idle_pct = idle_chance;
        repeat (count) send_word(random_word());
    endtask

    // ------------------------------------------------------------------------
    // Checker: every strobe must match the oldest expected character, in code
    // and in the last flag. The receiver cannot stall, so each strobe counts.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_strobe === 1'b1) begin
                if (pending_chars.size() == 0) begin
                    note_mismatch("character with nothing expected", 0, o_char_code);
                end else begin
                    want_char = pending_chars.pop_front();
                    if (o_char_code !== want_char.code) begin
                        note_mismatch("char_code", want_char.code, o_char_code);
                    end
                    if (o_last !== want_char.last) begin
                        note_mismatch("last", want_char.last, o_last);
                    end
                end
            end else if (o_strobe !== 1'b0) begin
                note_mismatch("strobe unknown", 0, o_strobe);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which no word is taken and no character
    // comes out.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start && busy === 1'b0) || o_strobe === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_value = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_values();
        test_random_words(70, 0);    // back to back
        test_random_words(70, 75);   // sender idle most of the time
        test_random_words(70, 34);   // sender idle now and then

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: signed_decimal_ascii_writer_unit.f
+incdir+hdl
hdl/sdaw_pkg.sv
hdl/sdaw_bcd_cell.sv
hdl/signed_decimal_ascii_writer_unit.sv
bench/testbench.sv
